[hdl/byte_histogram_offset_bucketing_macros.svh]
// Assertion macros used by the checker of this block.
`ifndef BYTE_HISTOGRAM_OFFSET_BUCKETING_MACROS_SVH
`define BYTE_HISTOGRAM_OFFSET_BUCKETING_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BHOB_ASSERT_NOW(label, clock, reset_n, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (ante) |-> (cons)) \
        else $error("bhob check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define BHOB_ASSERT_NEXT(label, clock, reset_n, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (ante) |=> (cons)) \
        else $error("bhob check failed in the next cycle");

`endif

[hdl/bhob_pkg.sv]
package bhob_pkg;

    localparam int ALPHABET = 256;
    localparam int ALPHA_W  = $clog2(ALPHABET);
    localparam int WALK_W   = ALPHA_W + 1;

    localparam logic [32:0] MAX_DOC_BYTES = 33'd16777216;
    localparam logic [24:0] COUNT_MAX     = 25'h1FF_FFFF;
    localparam logic [24:0] COUNT_CAP     = (MAX_DOC_BYTES < 33'(COUNT_MAX)) ?
                                            MAX_DOC_BYTES[24:0] : COUNT_MAX;

    localparam int CFG_W = 25;
    localparam int IDX_W = 1;

    localparam logic [24:0] REPEAT_FLOOR_RESET = 25'd1;
    localparam logic [15:0] HEADER_SKIP_RESET  = 16'd484;

    localparam logic [IDX_W-1:0] REG_REPEAT_FLOOR = 1'b0;
    localparam logic [IDX_W-1:0] REG_HEADER_SKIP  = 1'b1;

    localparam logic [1:0] OP_COUNT   = 2'd0;
    localparam logic [1:0] OP_END     = 2'd1;
    localparam logic [1:0] OP_PLACE   = 2'd2;
    localparam logic [1:0] OP_RESTART = 2'd3;

    localparam logic [1:0] KIND_CLOSED   = 2'd0;
    localparam logic [1:0] KIND_PLACED   = 2'd1;
    localparam logic [1:0] KIND_DOC_DONE = 2'd2;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  byte_value;
        logic [23:0] position;
        logic [23:0] slot;
        logic [8:0]  allowed_count;
        logic [24:0] total_entries;
    } result_t;

    typedef struct packed {
        logic load;
        logic do_count;
        logic do_place;
        logic do_restart;
        logic do_end_doc;
        logic begin_walk;
        logic walk;
        logic finish_close;
    } cmd_t;

    typedef struct packed {
        logic placing;
        logic walk_last;
    } status_t;

endpackage

[hdl/bhob_ctrl.sv]
module bhob_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        operation,
    input  bhob_pkg::status_t status,
    output bhob_pkg::cmd_t    cmd,
    output logic              busy
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_WALK = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic [1:0] op_reg;
    logic [1:0] op_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        op_next    = op_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    op_next    = operation;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                case (op_reg)
                    bhob_pkg::OP_COUNT:   cmd.do_count   = !status.placing;
                    bhob_pkg::OP_PLACE:   cmd.do_place   = status.placing;
                    bhob_pkg::OP_RESTART: cmd.do_restart = 1'b1;
                    bhob_pkg::OP_END:
                    begin
                        if (status.placing)
                        begin
                            cmd.do_end_doc = 1'b1;
                        end
                        else
                        begin
                            cmd.begin_walk = 1'b1;
                            state_next     = ST_WALK;
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_WALK:
            begin
                cmd.walk = 1'b1;
                if (status.walk_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                cmd.finish_close = 1'b1;
                state_next       = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= bhob_pkg::OP_COUNT;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

[hdl/bhob_datapath.sv]
module bhob_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bhob_pkg::item_t               item,
    input  bhob_pkg::cmd_t                cmd,
    output bhob_pkg::status_t             status,
    input  logic                          cfg_we,
    input  logic [bhob_pkg::IDX_W-1:0]    cfg_index,
    input  logic [bhob_pkg::CFG_W-1:0]    cfg_data,
    output logic                          done,
    output bhob_pkg::result_t             result
);

    localparam int AW = bhob_pkg::ALPHA_W;
    localparam int WW = bhob_pkg::WALK_W;
    localparam int NB = bhob_pkg::ALPHABET;

    // Histogram and bucket memories. Each bucket entry holds the allowed bit
    // above the next slot; after a restart every byte counts as allowed until
    // the next close rewrites all entries.
    logic [24:0] cnt_mem [NB];
    logic [24:0] bkt_mem [NB];
    logic [24:0] cnt_q;
    logic [24:0] bkt_q;
    logic [AW-1:0] cnt_raddr;
    logic [AW-1:0] bkt_raddr;
    logic          cnt_we;
    logic [AW-1:0] cnt_waddr;
    logic [24:0]   cnt_wdata;
    logic          bkt_we;
    logic [AW-1:0] bkt_waddr;
    logic [24:0]   bkt_wdata;

    logic [NB-1:0]  cnt_vld_reg,     cnt_vld_next;
    logic           fresh_reg,       fresh_next;
    logic [24:0]    min_rep_reg,     min_rep_next;
    logic [15:0]    hdr_skip_reg,    hdr_skip_next;
    logic [7:0]     byte_reg,        byte_next;
    logic [23:0]    pos_reg,         pos_next;
    logic [15:0]    skip_reg,        skip_next;
    logic           placing_reg,     placing_next;
    logic [WW-1:0]  walk_idx_reg,    walk_idx_next;
    logic           p_vld_reg,       p_vld_next;
    logic [AW-1:0]  p_idx_reg,       p_idx_next;
    logic [8:0]     acnt_reg,        acnt_next;
    logic [23:0]    start_reg,       start_next;
    logic [24:0]    total_reg,       total_next;
    logic           done_reg,        done_next;
    bhob_pkg::result_t result_reg,   result_next;

    logic [AW-1:0] bidx;
    logic [AW-1:0] vidx;
    logic          in_alpha;
    logic [24:0]   cnt_cur;
    logic          issue;
    logic          keep;
    logic [25:0]   total_sum;

    assign bidx      = byte_reg[AW-1:0];
    assign in_alpha  = (9'(byte_reg) < 9'(NB));
    assign vidx      = cmd.walk ? p_idx_reg : bidx;
    assign cnt_cur   = cnt_vld_reg[vidx] ? cnt_q : 25'd0;
    assign cnt_raddr = cmd.walk ? walk_idx_reg[AW-1:0] : item.data_byte[AW-1:0];
    assign bkt_raddr = cmd.walk ? walk_idx_reg[AW-1:0] : item.data_byte[AW-1:0];
    assign issue     = (walk_idx_reg < WW'(NB));
    assign keep      = (fresh_reg || bkt_q[24]) && (cnt_cur >= min_rep_reg);
    assign total_sum = {1'b0, total_reg} + {1'b0, cnt_cur};

    always_comb
    begin
        cnt_vld_next  = cnt_vld_reg;
        fresh_next    = fresh_reg;
        min_rep_next  = min_rep_reg;
        hdr_skip_next = hdr_skip_reg;
        byte_next     = byte_reg;
        pos_next      = pos_reg;
        skip_next     = skip_reg;
        placing_next  = placing_reg;
        walk_idx_next = walk_idx_reg;
        p_vld_next    = p_vld_reg;
        p_idx_next    = p_idx_reg;
        acnt_next     = acnt_reg;
        start_next    = start_reg;
        total_next    = total_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        cnt_we        = 1'b0;
        cnt_waddr     = bidx;
        cnt_wdata     = cnt_cur + 25'd1;
        bkt_we        = 1'b0;
        bkt_waddr     = vidx;
        bkt_wdata     = {1'b1, bkt_q[23:0] + 24'd1};

        if (cfg_we)
        begin
            case (cfg_index)
                bhob_pkg::REG_REPEAT_FLOOR: min_rep_next  = cfg_data;
                bhob_pkg::REG_HEADER_SKIP:  hdr_skip_next = cfg_data[15:0];
                default: min_rep_next = min_rep_reg;
            endcase
        end

        if (cmd.load)
        begin
            byte_next = item.data_byte;
        end

        if (cmd.do_count)
        begin
            if (skip_reg != 16'd0)
            begin
                skip_next = skip_reg - 16'd1;
            end
            else if (in_alpha && (cnt_cur < bhob_pkg::COUNT_CAP))
            begin
                cnt_we             = 1'b1;
                cnt_vld_next[bidx] = 1'b1;
            end
        end

        if (cmd.do_place)
        begin
            if (skip_reg != 16'd0)
            begin
                skip_next = skip_reg - 16'd1;
            end
            else
            begin
                pos_next = pos_reg + 24'd1;
                if (in_alpha && bkt_q[24])
                begin
                    bkt_we                    = 1'b1;
                    done_next                 = 1'b1;
                    result_next               = '0;
                    result_next.kind          = bhob_pkg::KIND_PLACED;
                    result_next.byte_value    = byte_reg;
                    result_next.position      = pos_reg;
                    result_next.slot          = bkt_q[23:0];
                end
            end
        end

        // A restart or the end of a document abandons the histogram at once.
        if (cmd.do_restart || cmd.do_end_doc)
        begin
            cnt_vld_next = '0;
            placing_next = 1'b0;
            pos_next     = 24'd0;
            skip_next    = hdr_skip_reg;
        end
        if (cmd.do_restart)
        begin
            fresh_next = 1'b1;
        end
        if (cmd.do_end_doc)
        begin
            done_next        = 1'b1;
            result_next      = '0;
            result_next.kind = bhob_pkg::KIND_DOC_DONE;
        end

        if (cmd.begin_walk)
        begin
            walk_idx_next = '0;
            p_vld_next    = 1'b0;
            acnt_next     = 9'd0;
            start_next    = 24'd0;
            total_next    = 25'd0;
        end

        // The walk reads one counter a cycle; the next cycle folds it into
        // the allowed set and the running bucket start.
        if (cmd.walk)
        begin
            p_vld_next = issue;
            p_idx_next = walk_idx_reg[AW-1:0];
            if (issue)
            begin
                walk_idx_next = walk_idx_reg + WW'(1);
            end
            if (p_vld_reg)
            begin
                bkt_we    = 1'b1;
                bkt_wdata = {keep, start_reg};
                if (keep)
                begin
                    acnt_next  = acnt_reg + 9'd1;
                    start_next = start_reg + cnt_cur[23:0];
                    total_next = (total_sum > 26'(bhob_pkg::COUNT_CAP)) ?
                                 bhob_pkg::COUNT_CAP : total_sum[24:0];
                end
            end
        end

        if (cmd.finish_close)
        begin
            fresh_next                = 1'b0;
            placing_next              = 1'b1;
            pos_next                  = 24'd0;
            skip_next                 = hdr_skip_reg;
            done_next                 = 1'b1;
            result_next               = '0;
            result_next.kind          = bhob_pkg::KIND_CLOSED;
            result_next.allowed_count = acnt_reg;
            result_next.total_entries = total_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_q <= cnt_mem[cnt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (bkt_we)
        begin
            bkt_mem[bkt_waddr] <= bkt_wdata;
        end
        bkt_q <= bkt_mem[bkt_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_vld_reg  <= '0;
            fresh_reg    <= 1'b1;
            min_rep_reg  <= bhob_pkg::REPEAT_FLOOR_RESET;
            hdr_skip_reg <= bhob_pkg::HEADER_SKIP_RESET;
            pos_reg      <= 24'd0;
            skip_reg     <= bhob_pkg::HEADER_SKIP_RESET;
            placing_reg  <= 1'b0;
            walk_idx_reg <= '0;
            p_vld_reg    <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            cnt_vld_reg  <= cnt_vld_next;
            fresh_reg    <= fresh_next;
            min_rep_reg  <= min_rep_next;
            hdr_skip_reg <= hdr_skip_next;
            pos_reg      <= pos_next;
            skip_reg     <= skip_next;
            placing_reg  <= placing_next;
            walk_idx_reg <= walk_idx_next;
            p_vld_reg    <= p_vld_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        p_idx_reg  <= p_idx_next;
        acnt_reg   <= acnt_next;
        start_reg  <= start_next;
        total_reg  <= total_next;
        result_reg <= result_next;
    end

    assign status.placing   = placing_reg;
    assign status.walk_last = p_vld_reg && (p_idx_reg == AW'(NB - 1));
    assign done             = done_reg;
    assign result           = result_reg;

endmodule

[hdl/byte_histogram_offset_bucketing.sv]
// Byte items (count or place), end items and restart items are accepted, then handled in the execute state.
// A placed-byte or document-finished result shows on result with done in the cycle after that.
// Closing the counting pass walks all 256 counters before its result appears.
// A new item is taken only while busy is low, once the previous item has finished.
// Reset (rst_n low, asynchronous) clears the histogram, allows every byte and loads defaults.
// Results cannot be stalled; each is valid for exactly one cycle.
module byte_histogram_offset_bucketing (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  bhob_pkg::item_t               item,
    output logic                          busy,
    output logic                          done,
    output bhob_pkg::result_t             result,
    input  logic                          cfg_we,
    input  logic [bhob_pkg::IDX_W-1:0]    cfg_index,
    input  logic [bhob_pkg::CFG_W-1:0]    cfg_data
);

    bhob_pkg::cmd_t    cmd;
    bhob_pkg::status_t status;

    bhob_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (item.operation),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy)
    );

    bhob_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

endmodule

[hdl/bhob_checker.sv]
`include "byte_histogram_offset_bucketing_macros.svh"

module bhob_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input bhob_pkg::result_t result
);

    // Every accepted item makes the block busy.
    `BHOB_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)

    // A result only appears once the block has gone back to idle.
    `BHOB_ASSERT_NOW(a_done_idle, clk, rst_n, done, !busy)

    // Results never come back to back.
    `BHOB_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)

    // A placed byte carries no pass summary.
    `BHOB_ASSERT_NOW(a_placed_clean, clk, rst_n,
        done && (result.kind == bhob_pkg::KIND_PLACED),
        (result.allowed_count == 9'd0) && (result.total_entries == 25'd0))

endmodule

bind byte_histogram_offset_bucketing bhob_checker u_checker (.*);

[tb/tb_byte_histogram_offset_bucketing.sv]
`timescale 1ns / 100ps

module tb_byte_histogram_offset_bucketing;

    localparam int BYTE_ITEM_TARGET = 1100;
    localparam int WATCHDOG_LIMIT   = 3000;
    localparam int DRAIN_CYCLES     = 300;

    // Tracks histogram, allowed set and bucket pointers, and queues expected results.
    class offset_bucket_tracker;
        bit [24:0] repeat_floor;
        bit [15:0] header_skip;
        bit [24:0] byte_counts [bhob_pkg::ALPHABET];
        bit        allowed [bhob_pkg::ALPHABET];
        bit [23:0] bucket_next [bhob_pkg::ALPHABET];
        bit [23:0] position;
        bit [15:0] skip_left;
        bit        placing;
        bhob_pkg::result_t pending_results [$];
        int        errors;

        function new();
            repeat_floor = bhob_pkg::REPEAT_FLOOR_RESET;
            header_skip = bhob_pkg::HEADER_SKIP_RESET;
            errors = 0;
            foreach (allowed[i])
            begin
                allowed[i] = 1'b1;
                bucket_next[i] = '0;
            end
            open_document();
        endfunction

        function void open_document();
            foreach (byte_counts[i])
                byte_counts[i] = '0;
            placing = 1'b0;
            position = '0;
            skip_left = header_skip;
        endfunction

        function void set_register(logic [bhob_pkg::IDX_W-1:0] idx,
                                   logic [bhob_pkg::CFG_W-1:0] value);
            if (idx == bhob_pkg::REG_REPEAT_FLOOR)
                repeat_floor = value;
            else if (idx == bhob_pkg::REG_HEADER_SKIP)
                header_skip = value[15:0];
        endfunction

        function void accept_item(bhob_pkg::item_t it);
            bhob_pkg::result_t r;
            bit [7:0]        b;
            bit              keep;
            bit [23:0]       start_slot;
            longint unsigned total;
            int              kept;
            r = '0;
            b = it.data_byte;
            case (it.operation)
                bhob_pkg::OP_RESTART:
                begin
                    foreach (allowed[i])
                        allowed[i] = 1'b1;
                    open_document();
                end
                bhob_pkg::OP_COUNT:
                begin
                    if (!placing)
                    begin
                        if (skip_left != 0)
                            skip_left--;
                        else if (byte_counts[b] < bhob_pkg::COUNT_CAP)
                            byte_counts[b]++;
                    end
                end
                bhob_pkg::OP_PLACE:
                begin
                    if (placing)
                    begin
                        if (skip_left != 0)
                            skip_left--;
                        else
                        begin
                            if (allowed[b])
                            begin
                                r.kind = bhob_pkg::KIND_PLACED;
                                r.byte_value = b;
                                r.position = position;
                                r.slot = bucket_next[b];
                                bucket_next[b]++;
                                pending_results = {pending_results, r};
                            end
                            position++;
                        end
                    end
                end
                bhob_pkg::OP_END:
                begin
                    if (!placing)
                    begin
                        kept = 0;
                        start_slot = '0;
                        total = 0;
                        for (int i = 0; i < bhob_pkg::ALPHABET; i++)
                        begin
                            keep = allowed[i] && (byte_counts[i] >= repeat_floor);
                            allowed[i] = keep;
                            bucket_next[i] = start_slot;
                            if (keep)
                            begin
                                kept++;
                                start_slot += byte_counts[i][23:0];
                                total += byte_counts[i];
                                if (total > bhob_pkg::COUNT_CAP)
                                    total = bhob_pkg::COUNT_CAP;
                            end
                        end
                        placing = 1'b1;
                        position = '0;
                        skip_left = header_skip;
                        r.kind = bhob_pkg::KIND_CLOSED;
                        r.allowed_count = kept[8:0];
                        r.total_entries = total[24:0];
                    end
                    else
                    begin
                        open_document();
                        r.kind = bhob_pkg::KIND_DOC_DONE;
                    end
                    pending_results = {pending_results, r};
                end
                default: ;
            endcase
        endfunction

        function void check_field(string name, logic [24:0] want, logic [24:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void compare_result(bhob_pkg::result_t got);
            bhob_pkg::result_t want;
            if (pending_results.size() == 0)
            begin
                $error("result with no item pending: kind %0d", got.kind);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            check_field("kind", 25'(want.kind), 25'(got.kind));
            check_field("byte_value", 25'(want.byte_value), 25'(got.byte_value));
            check_field("position", 25'(want.position), 25'(got.position));
            check_field("slot", 25'(want.slot), 25'(got.slot));
            check_field("allowed_count", 25'(want.allowed_count), 25'(got.allowed_count));
            check_field("total_entries", want.total_entries, got.total_entries);
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    bhob_pkg::item_t               item;
    logic                          busy;
    logic                          done;
    bhob_pkg::result_t             result;
    logic                          cfg_we;
    logic [bhob_pkg::IDX_W-1:0]    cfg_index;
    logic [bhob_pkg::CFG_W-1:0]    cfg_data;

    offset_bucket_tracker tracker;
    int                   idle_pct;
    int                   items_sent;
    int                   quiet_cycles;
    logic [7:0]           doc_bytes [$];

    byte_histogram_offset_bucketing uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            tracker.compare_result(result);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_we)
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("** byte_histogram_offset_bucketing: FAILED **");
                $finish;
            end
        end
    end

    task automatic send_item(logic [1:0] op, logic [7:0] data);
        bhob_pkg::item_t it;
        it.operation = op;
        it.data_byte = data;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        tracker.accept_item(it);
    endtask

    // Lets the block drain and go idle so that a register can be written safely.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (tracker.pending_results.size() != 0 || busy)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [bhob_pkg::IDX_W-1:0] idx,
                             logic [bhob_pkg::CFG_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.set_register(idx, value);
        @(posedge clk);
    endtask

    // One pass over doc_bytes with a random header and occasional wrong-phase items.
    task automatic run_pass(logic [1:0] op);
        logic [1:0] stray_op;
        stray_op = (op == bhob_pkg::OP_COUNT) ? bhob_pkg::OP_PLACE : bhob_pkg::OP_COUNT;
        repeat (tracker.header_skip)
            send_item(op, 8'($urandom));
        foreach (doc_bytes[k])
        begin
            if ($urandom_range(9) == 0)
                send_item(stray_op, 8'($urandom));
            send_item(op, doc_bytes[k]);
        end
        items_sent += tracker.header_skip + doc_bytes.size();
    endtask

    task automatic run_document();
        int         n;
        int         span;
        logic [7:0] base;
        n = $urandom_range(0, 24);
        base = 8'($urandom);
        span = ($urandom_range(3) == 0) ? 255 : $urandom_range(0, 7);
        doc_bytes.delete();
        for (int k = 0; k < n; k++)
            doc_bytes = {doc_bytes, 8'(base + $urandom_range(0, span))};
        run_pass(bhob_pkg::OP_COUNT);
        if ($urandom_range(19) == 0)
        begin
            send_item(bhob_pkg::OP_RESTART, 8'($urandom));
            items_sent++;
            return;
        end
        send_item(bhob_pkg::OP_END, 8'($urandom));
        // Mostly the same bytes again; sometimes a reordered or foreign second pass.
        case ($urandom_range(9))
            0: doc_bytes.shuffle();
            1:
            begin
                doc_bytes.delete();
                repeat ($urandom_range(0, 12))
                    doc_bytes = {doc_bytes, 8'($urandom)};
            end
            default: ;
        endcase
        run_pass(bhob_pkg::OP_PLACE);
        if ($urandom_range(19) == 0)
            send_item(bhob_pkg::OP_RESTART, 8'($urandom));
        else
            send_item(bhob_pkg::OP_END, 8'($urandom));
        items_sent += 2;
    endtask

    initial
    begin
        logic [bhob_pkg::CFG_W-1:0] threshold;
        tracker = new();
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idle_pct = 0;
        items_sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The reset header length is still in force, so these are swallowed.
        send_item(bhob_pkg::OP_COUNT, 8'h00);
        send_item(bhob_pkg::OP_COUNT, 8'hFF);
        send_item(bhob_pkg::OP_PLACE, 8'h7F);
        settle();
        write_reg(bhob_pkg::REG_HEADER_SKIP, 25'd1);
        write_reg(bhob_pkg::REG_REPEAT_FLOOR, 25'd0);
        send_item(bhob_pkg::OP_RESTART, 8'h00);

        // Zero threshold keeps every byte value, even ones never seen.
        send_item(bhob_pkg::OP_COUNT, 8'hAA);
        send_item(bhob_pkg::OP_COUNT, 8'h00);
        send_item(bhob_pkg::OP_COUNT, 8'hFF);
        send_item(bhob_pkg::OP_COUNT, 8'h00);
        send_item(bhob_pkg::OP_COUNT, 8'h80);
        send_item(bhob_pkg::OP_PLACE, 8'h00);
        send_item(bhob_pkg::OP_END, 8'h00);
        send_item(bhob_pkg::OP_PLACE, 8'h55);
        send_item(bhob_pkg::OP_PLACE, 8'h00);
        send_item(bhob_pkg::OP_PLACE, 8'hFF);
        send_item(bhob_pkg::OP_PLACE, 8'h00);
        send_item(bhob_pkg::OP_PLACE, 8'h80);
        send_item(bhob_pkg::OP_PLACE, 8'h10);
        send_item(bhob_pkg::OP_COUNT, 8'h01);
        send_item(bhob_pkg::OP_END, 8'hFF);

        // A threshold no byte reaches here empties the allowed set.
        settle();
        write_reg(bhob_pkg::REG_REPEAT_FLOOR, 25'h100_0000);
        send_item(bhob_pkg::OP_RESTART, 8'hFF);
        send_item(bhob_pkg::OP_COUNT, 8'h01);
        send_item(bhob_pkg::OP_COUNT, 8'h00);
        send_item(bhob_pkg::OP_COUNT, 8'h00);
        send_item(bhob_pkg::OP_END, 8'h00);
        send_item(bhob_pkg::OP_PLACE, 8'h01);
        send_item(bhob_pkg::OP_PLACE, 8'h00);
        send_item(bhob_pkg::OP_END, 8'h00);

        // Longest header: everything in both passes falls inside it.
        settle();
        write_reg(bhob_pkg::REG_HEADER_SKIP, 25'h1FF_FFFF);
        send_item(bhob_pkg::OP_RESTART, 8'h00);
        send_item(bhob_pkg::OP_COUNT, 8'h00);
        send_item(bhob_pkg::OP_COUNT, 8'hFF);
        send_item(bhob_pkg::OP_END, 8'h00);
        send_item(bhob_pkg::OP_PLACE, 8'h00);
        send_item(bhob_pkg::OP_END, 8'h00);
        settle();
        write_reg(bhob_pkg::REG_HEADER_SKIP, 25'd2);
        write_reg(bhob_pkg::REG_REPEAT_FLOOR, 25'd1);
        send_item(bhob_pkg::OP_RESTART, 8'h00);

        while (items_sent < BYTE_ITEM_TARGET)
        begin
            case (items_sent * 4 / BYTE_ITEM_TARGET)
                0: idle_pct = 0;
                1: idle_pct = 54;
                2: idle_pct = 30;
                default: idle_pct = 0;
            endcase
            if ($urandom_range(3) == 0)
            begin
                settle();
                case ($urandom_range(9))
                    0: threshold = 25'd0;
                    1: threshold = 25'h100_0000;
                    2: threshold = 25'($urandom_range(5, 25'h100_0000));
                    default: threshold = 25'($urandom_range(1, 4));
                endcase
                write_reg(bhob_pkg::REG_REPEAT_FLOOR, threshold);
                // Upper data bits are beyond the header register and must be dropped.
                write_reg(bhob_pkg::REG_HEADER_SKIP,
                          {9'($urandom), 16'($urandom_range(0, 3))});
                send_item(bhob_pkg::OP_RESTART, 8'($urandom));
            end
            else if ($urandom_range(1) == 0)
                send_item(bhob_pkg::OP_RESTART, 8'($urandom));
            run_document();
        end

        start <= 1'b0;
        @(posedge clk);
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.pending_results.size() != 0)
            $error("%0d expected results never arrived", tracker.pending_results.size());
        if (tracker.errors == 0 && tracker.pending_results.size() == 0)
            $display("** byte_histogram_offset_bucketing: PASSED **");
        else
            $display("** byte_histogram_offset_bucketing: FAILED **");
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/bhob_pkg.sv
hdl/bhob_ctrl.sv
hdl/bhob_datapath.sv
hdl/byte_histogram_offset_bucketing.sv
hdl/bhob_checker.sv
tb/tb_byte_histogram_offset_bucketing.sv
